// ===== hdl/lphm_pkg.sv =====
package lphm_pkg;

    // Table geometry
    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY);

    // Field widths
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int MAXE_W = 10;
    localparam int CNT_W  = 11;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MAX_ENTRIES = 1'b0;

    localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 10'd716;

    // Knuth multiplicative hash constant and the reserved empty-slot key
    localparam logic [31:0]      HASH_MULT   = 32'd2654435761;
    localparam logic [KEY_W-1:0] VACANT_MARK = 32'h8000_0000;

    typedef enum logic
    {
        REQ_LOOKUP = 1'b0,
        REQ_PUT    = 1'b1
    } req_t;

    typedef enum logic [STAT_W-1:0]
    {
        STAT_HIT      = 3'd0,
        STAT_MISS     = 3'd1,
        STAT_INSERTED = 3'd2,
        STAT_UPDATED  = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_RESERVED = 3'd5
    } status_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_CMP,
        ST_DONE
    } state_t;

    // Home slot: low bits of key * HASH_MULT. Only the low SLOT_W bits of
    // each operand reach the low SLOT_W bits of the product.
    function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] k);
        logic [2*SLOT_W-1:0] prod;
        begin
            prod = {{SLOT_W{1'b0}}, k[SLOT_W-1:0]} *
                   {{SLOT_W{1'b0}}, HASH_MULT[SLOT_W-1:0]};
            home_slot = prod[SLOT_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/lphm_ram.sv =====
module lphm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/linear_probe_hash_map.sv =====
// Flow: an item is accepted in ST_IDLE, its slot (first the home slot) is read in
//   ST_ADDR and compared in ST_CMP, and its result passes through ST_DONE into the
//   output register; each further probe repeats ST_ADDR and ST_CMP (one key/value
//   memory read, one compare). The reserved key goes from ST_IDLE to ST_DONE.
// Items: one at a time; s_tready stays low until ST_DONE loads the result, which
//   waits while the output is full. The single-read key memory paces the probe loop.
// Reset: rst_n clears control state, then the key memory is swept to the empty
//   marker, all CAPACITY (1024) slots, with s_tready low; max_entries resets to 716.
module linear_probe_hash_map (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,  // [31:0] key, [63:32] value
    input  logic                            s_tuser,  // [0] req_type
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,  // [31:0] read_value
    output logic [3:0]                      m_tuser,  // [0] found, [3:1] status
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lphm_pkg::PADDR_W-1:0]    paddr,
    input  logic [lphm_pkg::PDATA_W-1:0]    pwdata,
    output logic [lphm_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    import lphm_pkg::*;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_idx_reg;
    logic [CNT_W-1:0]    entry_count_reg;
    logic [MAXE_W-1:0]   max_entries_reg;

    // Item being worked on
    req_t                req_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [SLOT_W-1:0]   probe_idx_reg, probe_idx_next;
    logic [SLOT_W-1:0]   probe_cnt_reg, probe_cnt_next;

    // Result held until the output register is free
    logic                res_found_reg, res_found_next;
    logic [VAL_W-1:0]    res_value_reg, res_value_next;
    status_t             res_status_reg, res_status_next;

    // Output register
    logic                out_valid_reg;
    logic                out_found_reg;
    logic [VAL_W-1:0]    out_value_reg;
    status_t             out_status_reg;

    // Memory ports
    logic                key_we, val_we;
    logic [SLOT_W-1:0]   wr_addr;
    logic [KEY_W-1:0]    key_wdata;
    logic [KEY_W-1:0]    key_rdata;
    logic [VAL_W-1:0]    val_rdata;

    logic                in_fire;
    logic                out_load;
    logic                cfg_write;
    logic [KEY_W-1:0]    in_key;
    logic                key_empty, key_hit, last_probe, probe_end;
    logic                room;

    assign in_key    = s_tdata[KEY_W-1:0];
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign key_empty  = (key_rdata == VACANT_MARK);
    assign key_hit    = (key_rdata == key_reg);
    assign last_probe = (probe_cnt_reg == SLOT_W'(CAPACITY - 1));
    assign probe_end  = key_empty || key_hit || last_probe;
    assign room       = (entry_count_reg < CNT_W'(max_entries_reg));

    // In ST_DONE, load the output register when it is empty or being drained this cycle.
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    //------------------------------------------------------------------
    // Key and value stores; both read at the current probe slot.
    //------------------------------------------------------------------
    lphm_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .raddr (probe_idx_reg),
        .rdata (key_rdata)
    );

    lphm_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (val_reg),
        .raddr (probe_idx_reg),
        .rdata (val_rdata)
    );

    //------------------------------------------------------------------
    // Next state
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // Leave after the last slot is swept.
                if (clr_idx_reg == SLOT_W'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // The reserved key never touches the table.
                    state_next = (in_key == VACANT_MARK) ? ST_DONE : ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = probe_end ? ST_DONE : ST_ADDR;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Sequencer outputs: probe decision, memory writes, result fields
    //------------------------------------------------------------------
    always_comb
    begin
        s_tready        = (state_reg == ST_IDLE);
        key_we          = 1'b0;
        val_we          = 1'b0;
        wr_addr         = probe_idx_reg;
        key_wdata       = key_reg;
        probe_idx_next  = probe_idx_reg;
        probe_cnt_next  = probe_cnt_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the key store to the empty marker.
                key_we    = 1'b1;
                wr_addr   = clr_idx_reg;
                key_wdata = VACANT_MARK;
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    probe_idx_next  = home_slot(in_key);
                    probe_cnt_next  = '0;
                    res_found_next  = 1'b0;
                    res_value_next  = '0;
                    res_status_next = (req_t'(s_tuser) == REQ_PUT) ? STAT_RESERVED
                                                                   : STAT_MISS;
                end
            end
            ST_CMP:
            begin
                priority if (key_empty)
                begin
                    // First empty slot on the path: key is absent.
                    if (req_reg == REQ_LOOKUP)
                    begin
                        res_status_next = STAT_MISS;
                    end
                    else if (room)
                    begin
                        key_we          = 1'b1;
                        val_we          = 1'b1;
                        res_status_next = STAT_INSERTED;
                    end
                    else
                    begin
                        res_status_next = STAT_FULL;
                    end
                end
                else if (key_hit)
                begin
                    res_found_next = 1'b1;
                    if (req_reg == REQ_LOOKUP)
                    begin
                        res_value_next  = val_rdata;
                        res_status_next = STAT_HIT;
                    end
                    else
                    begin
                        val_we          = 1'b1;
                        res_status_next = STAT_UPDATED;
                    end
                end
                else if (last_probe)
                begin
                    // Whole table walked with no empty slot and no match.
                    res_status_next = (req_reg == REQ_LOOKUP) ? STAT_MISS : STAT_FULL;
                end
                else
                begin
                    probe_idx_next = probe_idx_reg + SLOT_W'(1);
                    probe_cnt_next = probe_cnt_reg + SLOT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    //------------------------------------------------------------------
    // Control registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_idx_reg     <= '0;
            entry_count_reg <= '0;
            max_entries_reg <= MAX_ENTRIES_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
            end
            // Count a new key each time a slot is claimed.
            if (key_we && (state_reg == ST_CMP))
            begin
                entry_count_reg <= entry_count_reg + CNT_W'(1);
            end
            if (cfg_write && (paddr[2] == REG_MAX_ENTRIES))
            begin
                max_entries_reg <= pwdata[MAXE_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Payload registers
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req_t'(s_tuser);
            key_reg <= in_key;
            val_reg <= s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        probe_idx_reg  <= probe_idx_next;
        probe_cnt_reg  <= probe_cnt_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_found_reg  <= res_found_reg;
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_status_reg, out_found_reg};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? PDATA_W'(max_entries_reg) : '0;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_claim_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && key_we) |-> (key_empty && req_reg == REQ_PUT))
        else $error("slot claimed that was not empty");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_count_reg <= CNT_W'(CAPACITY)))
        else $error("entry count exceeds table capacity");

    a_count_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(entry_count_reg) |-> ($past(res_status_next) == STAT_INSERTED))
        else $error("entry count moved without an insert");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("second item accepted while one is in flight");

    a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (res_status_reg == STAT_HIT || res_status_reg == STAT_UPDATED))
            |-> res_found_reg)
        else $error("hit or update reported without found");

endmodule
